[sv/cfc_pkg.sv]
// cfc_pkg: types and constants shared by the cuckoo flow counter modules
// no dependencies
package cfc_pkg;

  localparam int KEY_W   = 32;
  localparam int CNT_W   = 32;
  localparam int KICK_W  = 6;
  localparam int MODE_W  = 2;
  localparam int STAT_W  = 3;
  localparam logic [KICK_W-1:0] KICKS_RESET = 6'd4;

  typedef enum logic [MODE_W-1:0] {
    MODE_COUNT  = 2'd0,
    MODE_FIND   = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_SPARE  = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_INCR     = 3'd0,
    ST_PLACED   = 3'd1,
    ST_KICKED   = 3'd2,
    ST_DROPPED  = 3'd3,
    ST_FOUND    = 3'd4,
    ST_ABSENT   = 3'd5,
    ST_REMOVED  = 3'd6,
    ST_RMV_MISS = 3'd7
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK_RD,
    S_LOOK_EV,
    S_T1_RD,
    S_T1_EV,
    S_T2_RD,
    S_T2_EV,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clr_step;
    logic load;
    logic look_rd;
    logic look_do;
    logic t1_rd;
    logic t1_do;
    logic t2_rd;
    logic t2_do;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic is_count;
    logic hit;
    logic t1_empty;
    logic kicks_max;
    logic t2_empty;
  } sts_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a,
                                             input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_inc = s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

endpackage

[sv/cfc_if.sv]
// cfc_if: valid/ready channel carrying one beat of payload
// depends on nothing; payload width set by parameter
interface cfc_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/cfc_ram.sv]
// cfc_ram: single port ram with registered read
// no dependencies
module cfc_ram #(
  parameter int W = 32,
  parameter int D = 4096,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [W-1:0]  wdata,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [D];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[sv/cfc_ctrl.sv]
// cfc_ctrl: sequencer for lookup, eviction rounds and the clearing pass
// depends on cfc_pkg
module cfc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  cfc_pkg::sts_t sts,
  output cfc_pkg::cmd_t cmd
);
  cfc_pkg::state_t state_r, state_nxt;
  logic ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cfc_pkg::S_CLEAR;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cfc_pkg::S_CLEAR:   if (sts.clr_done) state_nxt = cfc_pkg::S_IDLE;
      cfc_pkg::S_IDLE:    if (in_valid) state_nxt = cfc_pkg::S_LOOK_RD;
      cfc_pkg::S_LOOK_RD: state_nxt = cfc_pkg::S_LOOK_EV;
      cfc_pkg::S_LOOK_EV: begin
        if (sts.hit || !sts.is_count) state_nxt = cfc_pkg::S_OUT;
        else state_nxt = cfc_pkg::S_T1_RD;
      end
      cfc_pkg::S_T1_RD:   state_nxt = cfc_pkg::S_T1_EV;
      cfc_pkg::S_T1_EV: begin
        if (sts.t1_empty || sts.kicks_max) state_nxt = cfc_pkg::S_OUT;
        else state_nxt = cfc_pkg::S_T2_RD;
      end
      cfc_pkg::S_T2_RD:   state_nxt = cfc_pkg::S_T2_EV;
      cfc_pkg::S_T2_EV: begin
        if (sts.t2_empty) state_nxt = cfc_pkg::S_OUT;
        else state_nxt = cfc_pkg::S_T1_RD;
      end
      cfc_pkg::S_OUT:     if (!ov_r || out_ready) state_nxt = cfc_pkg::S_IDLE;
      default:            state_nxt = cfc_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    ov_nxt = ov_r && !out_ready;
    case (state_r)
      cfc_pkg::S_CLEAR:   cmd.clr_step = 1'b1;
      cfc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      cfc_pkg::S_LOOK_RD: cmd.look_rd = 1'b1;
      cfc_pkg::S_LOOK_EV: cmd.look_do = 1'b1;
      cfc_pkg::S_T1_RD:   cmd.t1_rd = 1'b1;
      cfc_pkg::S_T1_EV:   cmd.t1_do = 1'b1;
      cfc_pkg::S_T2_RD:   cmd.t2_rd = 1'b1;
      cfc_pkg::S_T2_EV:   cmd.t2_do = 1'b1;
      cfc_pkg::S_OUT: begin
        if (!ov_r || out_ready) begin
          cmd.out_load = 1'b1;
          ov_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = ov_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == cfc_pkg::S_IDLE) else $error("accept outside idle");
  a_load_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> $stable(ov_r)) else $error("result lost");
  a_look_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.look_rd |=> cmd.look_do) else $error("lookup sequence");
endmodule

[sv/cfc_dp.sv]
// cfc_dp: key and count tables, cuckoo move registers, tallies, result register
// depends on cfc_pkg and cfc_ram
module cfc_dp #(
  parameter int TABLE_SIZE = 4096,
  localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cfc_pkg::cmd_t              cmd,
  output cfc_pkg::sts_t              sts,
  input  logic                       cfg_we,
  input  logic [cfc_pkg::KICK_W-1:0] cfg_data,
  input  logic [cfc_pkg::MODE_W-1:0] in_mode,
  input  logic [cfc_pkg::KEY_W-1:0]  in_key,
  output logic [cfc_pkg::STAT_W-1:0] o_status,
  output logic [cfc_pkg::CNT_W-1:0]  o_count,
  output logic [cfc_pkg::KICK_W-1:0] o_kicks,
  output logic [cfc_pkg::KEY_W-1:0]  o_dropped,
  output logic [cfc_pkg::CNT_W-1:0]  o_conf,
  output logic [cfc_pkg::CNT_W-1:0]  o_ktot
);
  localparam int KW = cfc_pkg::KEY_W;
  localparam int CW = cfc_pkg::CNT_W;
  localparam int NW = cfc_pkg::KICK_W;

  logic [NW-1:0] maxk_r;
  logic [1:0]    mode_r;
  logic [KW-1:0] key_r, k_r, k_nxt;
  logic [CW-1:0] c_r, c_nxt;
  logic [NW-1:0] kicks_r, kicks_nxt;
  logic [CW-1:0] conf_r, conf_nxt, ktot_r, ktot_nxt;
  logic [cfc_pkg::STAT_W-1:0] stat_r, stat_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [KW-1:0] drop_r, drop_nxt;
  logic [AW:0]   clr_r;

  logic          we1, we2;
  logic [AW-1:0] a1, a2;
  logic [KW-1:0] wk1, wk2, rk1, rk2;
  logic [CW-1:0] wc1, wc2, rc1, rc2;

  function automatic logic [AW-1:0] slot1(input logic [KW-1:0] k);
    slot1 = AW'(k % TABLE_SIZE);
  endfunction

  function automatic logic [AW-1:0] slot2(input logic [KW-1:0] k);
    logic [KW-1:0] t;
    t = KW'(k * 3) + KW'(7);
    slot2 = AW'(t % TABLE_SIZE);
  endfunction

  cfc_ram #(.W(KW), .D(TABLE_SIZE)) u_k1 (.clk, .we(we1), .addr(a1), .wdata(wk1), .rdata(rk1));
  cfc_ram #(.W(CW), .D(TABLE_SIZE)) u_c1 (.clk, .we(we1), .addr(a1), .wdata(wc1), .rdata(rc1));
  cfc_ram #(.W(KW), .D(TABLE_SIZE)) u_k2 (.clk, .we(we2), .addr(a2), .wdata(wk2), .rdata(rk2));
  cfc_ram #(.W(CW), .D(TABLE_SIZE)) u_c2 (.clk, .we(we2), .addr(a2), .wdata(wc2), .rdata(rc2));

  wire h1 = (rc1 != '0) && (rk1 == key_r);
  wire hh2 = !h1 && (rc2 != '0) && (rk2 == key_r);

  always_comb begin
    we1 = 1'b0; we2 = 1'b0;
    a1 = slot1(key_r); a2 = slot2(key_r);
    wk1 = '0; wc1 = '0; wk2 = '0; wc2 = '0;
    k_nxt = k_r; c_nxt = c_r; kicks_nxt = kicks_r;
    conf_nxt = conf_r; ktot_nxt = ktot_r;
    stat_nxt = stat_r; cnt_nxt = cnt_r; drop_nxt = drop_r;
    if (cmd.clr_step) begin
      we1 = 1'b1; we2 = 1'b1;
      a1 = clr_r[AW-1:0]; a2 = clr_r[AW-1:0];
    end
    if (cmd.load) begin
      k_nxt = in_key; c_nxt = CW'(1); kicks_nxt = '0;
      cnt_nxt = '0; drop_nxt = '0;
    end
    if (cmd.look_do) begin
      case (cfc_pkg::mode_t'(mode_r))
        cfc_pkg::MODE_COUNT: begin
          if (h1) begin
            we1 = 1'b1; wk1 = rk1; wc1 = cfc_pkg::sat_inc(rc1, CW'(1));
            cnt_nxt = wc1; stat_nxt = cfc_pkg::ST_INCR;
          end else if (hh2) begin
            we2 = 1'b1; wk2 = rk2; wc2 = cfc_pkg::sat_inc(rc2, CW'(1));
            cnt_nxt = wc2; stat_nxt = cfc_pkg::ST_INCR;
          end
        end
        cfc_pkg::MODE_REMOVE: begin
          if (h1) begin
            we1 = 1'b1; stat_nxt = cfc_pkg::ST_REMOVED;
          end else if (hh2) begin
            we2 = 1'b1; stat_nxt = cfc_pkg::ST_REMOVED;
          end else begin
            stat_nxt = cfc_pkg::ST_RMV_MISS;
          end
        end
        default: begin
          if (h1) begin
            cnt_nxt = rc1; stat_nxt = cfc_pkg::ST_FOUND;
          end else if (hh2) begin
            cnt_nxt = rc2; stat_nxt = cfc_pkg::ST_FOUND;
          end else begin
            stat_nxt = cfc_pkg::ST_ABSENT;
          end
        end
      endcase
    end
    if (cmd.t1_rd) a1 = slot1(k_r);
    if (cmd.t1_do) begin
      a1 = slot1(k_r);
      if (rc1 == '0) begin
        we1 = 1'b1; wk1 = k_r; wc1 = c_r;
        stat_nxt = (kicks_r != '0) ? cfc_pkg::ST_KICKED : cfc_pkg::ST_PLACED;
        cnt_nxt = CW'(1);
        ktot_nxt = cfc_pkg::sat_inc(ktot_r, CW'(kicks_r));
      end else if (kicks_r >= maxk_r) begin
        stat_nxt = cfc_pkg::ST_DROPPED;
        drop_nxt = k_r;
        conf_nxt = cfc_pkg::sat_inc(conf_r, CW'(1));
        cnt_nxt = (k_r == key_r) ? '0 : CW'(1);
        ktot_nxt = cfc_pkg::sat_inc(ktot_r, CW'(kicks_r));
      end else begin
        we1 = 1'b1; wk1 = k_r; wc1 = c_r;
        k_nxt = rk1; c_nxt = rc1;
        kicks_nxt = kicks_r + NW'(1);
      end
    end
    if (cmd.t2_rd) a2 = slot2(k_r);
    if (cmd.t2_do) begin
      a2 = slot2(k_r);
      we2 = 1'b1; wk2 = k_r; wc2 = c_r;
      if (rc2 == '0) begin
        stat_nxt = cfc_pkg::ST_KICKED;
        cnt_nxt = CW'(1);
        ktot_nxt = cfc_pkg::sat_inc(ktot_r, CW'(kicks_r));
      end else begin
        k_nxt = rk2; c_nxt = rc2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxk_r <= cfc_pkg::KICKS_RESET;
      conf_r <= '0;
      ktot_r <= '0;
      clr_r  <= '0;
    end else begin
      if (cfg_we) maxk_r <= cfg_data;
      conf_r <= conf_nxt;
      ktot_r <= ktot_nxt;
      if (cmd.clr_step) clr_r <= clr_r + (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      key_r  <= in_key;
    end
    k_r <= k_nxt; c_r <= c_nxt; kicks_r <= kicks_nxt;
    stat_r <= stat_nxt; cnt_r <= cnt_nxt; drop_r <= drop_nxt;
    if (cmd.out_load) begin
      o_status  <= stat_r;
      o_count   <= cnt_r;
      o_kicks   <= kicks_r;
      o_dropped <= drop_r;
      o_conf    <= conf_r;
      o_ktot    <= ktot_r;
    end
  end

  assign sts.clr_done  = (clr_r == (AW+1)'(TABLE_SIZE - 1));
  assign sts.is_count  = (mode_r == cfc_pkg::MODE_COUNT);
  assign sts.hit       = h1 || hh2;
  assign sts.t1_empty  = (rc1 == '0);
  assign sts.kicks_max = (kicks_r >= maxk_r);
  assign sts.t2_empty  = (rc2 == '0);

  a_kick_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.t1_do |-> kicks_r <= maxk_r || $past(cfg_we)) else $error("kick over limit");
  a_carry_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.t2_do |-> c_r != '0) else $error("moving an empty slot");
  a_conf_mono: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.clr_step |=> conf_r >= $past(conf_r)) else $error("tally went back");
endmodule

[sv/cuckoo_flow_counter.sv]
// cuckoo_flow_counter: top level, two-way cuckoo table counting 32-bit keys
// depends on cfc_pkg, cfc_if, cfc_ctrl, cfc_dp, cfc_ram
//
// channel  dir  payload
// in       in   mode[1:0], key[31:0]
// out      out  status, count, kicks, dropped_key, conflict_total, kick_total
// cfg      in   max_kicks[5:0] (write only)
//
// find, remove and a count that hits go through read, decide and result steps
// a count that misses adds a read and a decide step per table-one round and per table-two round
// all four tables are single port rams, one access per cycle sets the pace
// after reset a clearing pass empties every ram address, no beat taken
// the result register frees the datapath once the result beat is loaded
module cuckoo_flow_counter #(
  parameter int TABLE_SIZE = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  cfc_if.sink                        in_ch,
  cfc_if.source                      out_ch,
  input  logic                       cfg_we,
  input  logic [cfc_pkg::KICK_W-1:0] cfg_data
);
  cfc_pkg::cmd_t cmd;
  cfc_pkg::sts_t sts;

  cfc_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd
  );

  cfc_dp #(.TABLE_SIZE(TABLE_SIZE)) u_dp (
    .clk, .rst_n, .cmd, .sts, .cfg_we, .cfg_data,
    .in_mode(in_ch.data[33:32]), .in_key(in_ch.data[31:0]),
    .o_status(out_ch.data[136:134]), .o_count(out_ch.data[133:102]),
    .o_kicks(out_ch.data[101:96]), .o_dropped(out_ch.data[95:64]),
    .o_conf(out_ch.data[63:32]), .o_ktot(out_ch.data[31:0])
  );
endmodule

[tb/cuckoo_flow_counter_tb.sv]
// cuckoo_flow_counter_tb: self-checking bench for the two-way cuckoo flow counter
// depends on cfc_pkg, cfc_if and cuckoo_flow_counter; own table model predicts each untyped row's result
module cuckoo_flow_counter_tb;

  localparam int TBL = 4096;
  localparam int IN_W = cfc_pkg::MODE_W + cfc_pkg::KEY_W;
  localparam int OUT_W = cfc_pkg::STAT_W + cfc_pkg::CNT_W + cfc_pkg::KICK_W
                       + cfc_pkg::KEY_W + cfc_pkg::CNT_W + cfc_pkg::CNT_W;
  localparam int RAND_ITEMS = 1000;

  typedef struct packed {
    cfc_pkg::status_t                 status;
    logic [cfc_pkg::CNT_W-1:0]        count;
    logic [cfc_pkg::KICK_W-1:0]       kicks;
    logic [cfc_pkg::KEY_W-1:0]        dropped_key;
    logic [cfc_pkg::CNT_W-1:0]        conflict_total;
    logic [cfc_pkg::CNT_W-1:0]        kick_total;
  } flow_result_t;

  typedef struct {
    cfc_pkg::mode_t mode;
    logic [31:0]    key;
    bit             typed;
    flow_result_t   res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [cfc_pkg::KICK_W-1:0] cfg_data = '0;

  cfc_if #(.W(IN_W))  in_ch ();
  cfc_if #(.W(OUT_W)) out_ch ();

  cuckoo_flow_counter #(.TABLE_SIZE(TBL)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [31:0] t1_key [TBL];
  logic [31:0] t1_cnt [TBL];
  logic [31:0] t2_key [TBL];
  logic [31:0] t2_cnt [TBL];
  logic [31:0] drop_tally;
  logic [31:0] evict_tally;
  logic [5:0]  kick_limit;

  flow_result_t pending_results[$];
  int errors = 0;
  bit calm = 1'b0;
  int in_gap = 0;
  int out_gap = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < TBL; i++) begin
      t1_key[i] = '0;
      t1_cnt[i] = '0;
      t2_key[i] = '0;
      t2_cnt[i] = '0;
    end
    drop_tally = '0;
    evict_tally = '0;
    kick_limit = cfc_pkg::KICKS_RESET;
  end

  function automatic logic [31:0] sat1(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic int home1(logic [31:0] k);
    return int'(k % TBL);
  endfunction

  function automatic int home2(logic [31:0] k);
    logic [31:0] h;
    h = k * 32'd3 + 32'd7;
    return int'(h % TBL);
  endfunction

  function automatic flow_result_t count_lookup(cfc_pkg::mode_t mode, logic [31:0] key);
    flow_result_t r;
    int a, b, i, j, n;
    bit hit1, hit2, done;
    logic [31:0] k, c, tk, tc;
    a = home1(key);
    b = home2(key);
    hit1 = t1_cnt[a] != 0 && t1_key[a] == key;
    hit2 = !hit1 && t2_cnt[b] != 0 && t2_key[b] == key;
    r = '0;
    n = 0;
    if (mode == cfc_pkg::MODE_COUNT) begin
      if (hit1) begin
        t1_cnt[a] = sat1(t1_cnt[a], 1);
        r.count = t1_cnt[a];
        r.status = cfc_pkg::ST_INCR;
      end else if (hit2) begin
        t2_cnt[b] = sat1(t2_cnt[b], 1);
        r.count = t2_cnt[b];
        r.status = cfc_pkg::ST_INCR;
      end else begin
        k = key;
        c = 1;
        done = 1'b0;
        while (!done) begin
          i = home1(k);
          if (t1_cnt[i] == 0) begin
            t1_key[i] = k;
            t1_cnt[i] = c;
            r.status = (n != 0) ? cfc_pkg::ST_KICKED : cfc_pkg::ST_PLACED;
            done = 1'b1;
          end else if (n >= kick_limit) begin
            r.status = cfc_pkg::ST_DROPPED;
            r.dropped_key = k;
            drop_tally = sat1(drop_tally, 1);
            done = 1'b1;
          end else begin
            n++;
            tk = t1_key[i];
            tc = t1_cnt[i];
            t1_key[i] = k;
            t1_cnt[i] = c;
            k = tk;
            c = tc;
            j = home2(k);
            if (t2_cnt[j] == 0) begin
              t2_key[j] = k;
              t2_cnt[j] = c;
              r.status = cfc_pkg::ST_KICKED;
              done = 1'b1;
            end else begin
              tk = t2_key[j];
              tc = t2_cnt[j];
              t2_key[j] = k;
              t2_cnt[j] = c;
              k = tk;
              c = tc;
            end
          end
        end
        r.count = (r.status == cfc_pkg::ST_DROPPED && r.dropped_key == key) ? 32'd0 : 32'd1;
        r.kicks = n[5:0];
        evict_tally = sat1(evict_tally, n);
      end
    end else if (mode == cfc_pkg::MODE_REMOVE) begin
      if (hit1) begin
        t1_key[a] = '0;
        t1_cnt[a] = '0;
        r.status = cfc_pkg::ST_REMOVED;
      end else if (hit2) begin
        t2_key[b] = '0;
        t2_cnt[b] = '0;
        r.status = cfc_pkg::ST_REMOVED;
      end else begin
        r.status = cfc_pkg::ST_RMV_MISS;
      end
    end else begin
      if (hit1) begin
        r.count = t1_cnt[a];
        r.status = cfc_pkg::ST_FOUND;
      end else if (hit2) begin
        r.count = t2_cnt[b];
        r.status = cfc_pkg::ST_FOUND;
      end else begin
        r.status = cfc_pkg::ST_ABSENT;
      end
    end
    r.conflict_total = drop_tally;
    r.kick_total = evict_tally;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic queue_expect(flow_result_t r);
    pending_results = {pending_results, r};
  endtask

  // send one beat, predict at acceptance
  task automatic send_item(cfc_pkg::mode_t mode, logic [31:0] key, bit typed,
                           flow_result_t res);
    flow_result_t p;
    if (!calm && $urandom_range(3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= {mode, key};
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    p = count_lookup(mode, key);
    queue_expect(typed ? res : p);
  endtask

  task automatic write_kick_limit(logic [5:0] v);
    @(posedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    kick_limit = v;
  endtask

  function automatic logic [31:0] pick_key();
    int sel;
    sel = $urandom_range(9);
    if (sel < 7)
      return {16'($urandom_range(15)), 4'h0, 12'($urandom_range(7))};
    return $urandom;
  endfunction

  function automatic cfc_pkg::mode_t pick_mode();
    int sel;
    sel = $urandom_range(19);
    if (sel < 12) return cfc_pkg::MODE_COUNT;
    if (sel < 16) return cfc_pkg::MODE_FIND;
    if (sel < 19) return cfc_pkg::MODE_REMOVE;
    return cfc_pkg::MODE_SPARE;
  endfunction

  // result side
  always @(posedge clk) begin
    if (!calm && out_gap == 0 && $urandom_range(4) == 0)
      out_gap = $urandom_range(1, 4);
    if (out_gap > 0 && !calm) begin
      out_ch.ready <= 1'b0;
      out_gap--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(negedge clk) begin
    flow_result_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", got.status, '0);
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.count != want.count) report_mismatch("count", got.count, want.count);
        if (got.kicks != want.kicks) report_mismatch("kicks", got.kicks, want.kicks);
        if (got.dropped_key != want.dropped_key)
          report_mismatch("dropped_key", got.dropped_key, want.dropped_key);
        if (got.conflict_total != want.conflict_total)
          report_mismatch("conflict_total", got.conflict_total, want.conflict_total);
        if (got.kick_total != want.kick_total)
          report_mismatch("kick_total", got.kick_total, want.kick_total);
      end
    end
  end

  stim_row_t directed[] = '{
    '{cfc_pkg::MODE_FIND,   32'h0000_0000, 1, '{cfc_pkg::ST_ABSENT,   0, 0, 0, 0, 0}},
    '{cfc_pkg::MODE_REMOVE, 32'h0000_0000, 1, '{cfc_pkg::ST_RMV_MISS, 0, 0, 0, 0, 0}},
    '{cfc_pkg::MODE_COUNT,  32'h0000_0000, 1, '{cfc_pkg::ST_PLACED,   1, 0, 0, 0, 0}},
    '{cfc_pkg::MODE_COUNT,  32'h0000_0000, 1, '{cfc_pkg::ST_INCR,     2, 0, 0, 0, 0}},
    '{cfc_pkg::MODE_FIND,   32'h0000_0000, 1, '{cfc_pkg::ST_FOUND,    2, 0, 0, 0, 0}},
    '{cfc_pkg::MODE_SPARE,  32'hFFFF_FFFF, 1, '{cfc_pkg::ST_ABSENT,   0, 0, 0, 0, 0}},
    '{cfc_pkg::MODE_COUNT,  32'hFFFF_FFFF, 0, '0},
    '{cfc_pkg::MODE_SPARE,  32'hFFFF_FFFF, 0, '0},
    '{cfc_pkg::MODE_COUNT,  32'h0000_1000, 0, '0},
    '{cfc_pkg::MODE_COUNT,  32'h0000_2000, 0, '0},
    '{cfc_pkg::MODE_COUNT,  32'h0000_3000, 0, '0},
    '{cfc_pkg::MODE_COUNT,  32'h0000_4000, 0, '0},
    '{cfc_pkg::MODE_COUNT,  32'h0000_5000, 0, '0},
    '{cfc_pkg::MODE_COUNT,  32'h0000_6000, 0, '0},
    '{cfc_pkg::MODE_COUNT,  32'h0000_7000, 0, '0},
    '{cfc_pkg::MODE_FIND,   32'h0000_0000, 0, '0},
    '{cfc_pkg::MODE_FIND,   32'h0000_1000, 0, '0},
    '{cfc_pkg::MODE_COUNT,  32'h0000_1000, 0, '0},
    '{cfc_pkg::MODE_REMOVE, 32'h0000_1000, 0, '0},
    '{cfc_pkg::MODE_REMOVE, 32'h0000_0000, 0, '0},
    '{cfc_pkg::MODE_FIND,   32'h0000_1000, 0, '0},
    '{cfc_pkg::MODE_COUNT,  32'h8000_0000, 0, '0},
    '{cfc_pkg::MODE_COUNT,  32'hAAAA_5555, 0, '0}
  };

  logic [5:0] kick_plan [5] = '{6'd0, 6'd1, 6'd63, 6'd2, 6'd4};

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[i])
      send_item(directed[i].mode, directed[i].key, directed[i].typed, directed[i].res);
    for (int ph = 0; ph < 5; ph++) begin
      write_kick_limit(kick_plan[ph]);
      if (ph == 4) write_kick_limit(6'($urandom_range(3, 62)));
      if (ph == 4) calm = 1'b1;
      for (int n = 0; n < RAND_ITEMS / 5; n++)
        send_item(pick_mode(), pick_key(), 1'b0, '0);
    end
    @(posedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #80_000_000;
    $display("timeout at %0t", $realtime);
    $display("== FAIL ==");
    $finish;
  end

endmodule
